// ===== rtl/ica_pkg.sv =====
// Shared types and constants for the integer calculator ALU.
package ica_pkg;

  // Opcodes carried in the request
  typedef logic [3:0] op_t;
  localparam op_t OP_ADD    = 4'd0;
  localparam op_t OP_SUB    = 4'd1;
  localparam op_t OP_MUL    = 4'd2;
  localparam op_t OP_DIV    = 4'd3;
  localparam op_t OP_MOD    = 4'd4;
  localparam op_t OP_POW    = 4'd5;
  localparam op_t OP_SQUARE = 4'd6;
  localparam op_t OP_CUBE   = 4'd7;
  localparam op_t OP_ROOT   = 4'd8;
  localparam op_t OP_PASS   = 4'd9;

  // Status codes returned with each result
  typedef logic [2:0] stat_t;
  localparam stat_t ST_OK        = 3'd0;
  localparam stat_t ST_DIV_ZERO  = 3'd1;
  localparam stat_t ST_MOD_ZERO  = 3'd2;
  localparam stat_t ST_ROOT_NEG  = 3'd3;
  localparam stat_t ST_BAD_OP    = 3'd4;

  // Value returned for a zero divisor (-999999)
  localparam logic [31:0] DIV_ZERO_VALUE = 32'hFFF0_BDC1;
  // Upper bound of the root search
  localparam logic [15:0] ROOT_HI = 16'd46341;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_MUL1,
    S_MUL2,
    S_POW_MUL,
    S_POW_SQ,
    S_ABS_A,
    S_ABS_B,
    S_DIV,
    S_DIV_FIX,
    S_ROOT_MID,
    S_ROOT_MUL,
    S_ROOT_CMP,
    S_DONE
  } state_t;

  // Request into the engine
  typedef struct packed {
    op_t         cmd;
    logic [31:0] a;
    logic [31:0] b;
  } req_t;

  // Result out of the engine
  typedef struct packed {
    logic [31:0] value;
    stat_t       status;
  } rsp_t;

endpackage

// ===== rtl/ica_engine.sv =====
// Sequencer with one shared multiplier and one shared adder for the calculator ALU.
module ica_engine
  import ica_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  input  logic take,
  output logic idle,
  output logic done,
  output rsp_t rsp
);

  state_t      state, state_next;
  op_t         cmd_r;
  logic [31:0] opa, opb;
  logic [31:0] acc, aux, rem;
  logic [4:0]  cnt;
  logic [15:0] lo, hi, mid;
  logic [31:0] res_value;
  stat_t       res_status;

  // Shared unit operands
  logic [33:0] add_x, add_y, add_sum;
  logic        add_sub, borrow;
  logic [31:0] mul_x, mul_y, mul_p;
  logic [63:0] mul_full;
  logic [16:0] mid_inc;
  logic [31:0] fix_val;
  logic        fix_neg;

  // Shared adder/subtractor
  assign add_sum  = add_x + (add_sub ? ~add_y : add_y) + {33'b0, add_sub};
  assign borrow   = add_sum[33];
  // Shared multiplier, low word only
  assign mul_full = mul_x * mul_y;
  assign mul_p    = mul_full[31:0];
  assign mid_inc  = {1'b0, mid} + 17'd1;
  // Sign fixup after division
  assign fix_val  = (cmd_r == OP_DIV) ? acc : rem;
  assign fix_neg  = (cmd_r == OP_DIV) ? (opa[31] ^ opb[31]) : opa[31];

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req.cmd) inside
            OP_ADD, OP_SUB:             state_next = S_ADD;
            OP_MUL, OP_SQUARE, OP_CUBE: state_next = S_MUL1;
            OP_DIV, OP_MOD:             state_next = (req.b == 32'd0) ? S_DONE : S_ABS_A;
            OP_POW:                     state_next = req.b[31] ? S_DONE : S_POW_MUL;
            OP_ROOT: begin
              state_next = (req.a[31] || req.a == 32'd0) ? S_DONE : S_ROOT_MID;
            end
            default:                    state_next = S_DONE;
          endcase
        end
      end
      S_ADD:      state_next = S_DONE;
      S_MUL1:     state_next = (cmd_r == OP_CUBE) ? S_MUL2 : S_DONE;
      S_MUL2:     state_next = S_DONE;
      S_POW_MUL:  state_next = S_POW_SQ;
      S_POW_SQ:   state_next = (rem[31:1] == 31'd0) ? S_DONE : S_POW_MUL;
      S_ABS_A:    state_next = S_ABS_B;
      S_ABS_B:    state_next = S_DIV;
      S_DIV:      state_next = (cnt == 5'd31) ? S_DIV_FIX : S_DIV;
      S_DIV_FIX:  state_next = S_DONE;
      S_ROOT_MID: state_next = (lo == hi) ? S_DONE : S_ROOT_MUL;
      S_ROOT_MUL: state_next = S_ROOT_CMP;
      S_ROOT_CMP: state_next = S_ROOT_MID;
      S_DONE:     state_next = take ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Shared unit operand selection and handshake outputs
  always_comb begin
    add_x   = 34'd0;
    add_y   = 34'd0;
    add_sub = 1'b0;
    mul_x   = acc;
    mul_y   = aux;
    idle    = 1'b0;
    done    = 1'b0;
    unique case (state)
      S_IDLE: idle = 1'b1;
      S_ADD: begin
        add_x   = {2'b0, opa};
        add_y   = {2'b0, opb};
        add_sub = (cmd_r == OP_SUB);
      end
      S_MUL1: begin
        mul_x = opa;
        mul_y = (cmd_r == OP_MUL) ? opb : opa;
      end
      S_MUL2: begin
        mul_x = acc;
        mul_y = opa;
      end
      S_POW_MUL: begin
        mul_x = acc;
        mul_y = aux;
      end
      S_POW_SQ: begin
        mul_x = aux;
        mul_y = aux;
      end
      S_ABS_A: begin
        add_y   = {2'b0, opa};
        add_sub = 1'b1;
      end
      S_ABS_B: begin
        add_y   = {2'b0, opb};
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_x   = {1'b0, rem, acc[31]};
        add_y   = {2'b0, aux};
        add_sub = 1'b1;
      end
      S_DIV_FIX: begin
        add_y   = {2'b0, fix_val};
        add_sub = 1'b1;
      end
      S_ROOT_MID: begin
        add_x = {18'b0, lo};
        add_y = {18'b0, hi};
      end
      S_ROOT_MUL: begin
        mul_x = {16'b0, mid};
        mul_y = {15'b0, mid_inc};
      end
      S_ROOT_CMP: begin
        add_x   = {2'b0, rem};
        add_y   = {2'b0, opa};
        add_sub = 1'b1;
      end
      S_DONE: done = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r      <= req.cmd;
          opa        <= req.a;
          opb        <= req.b;
          acc        <= 32'd1;
          aux        <= req.a;
          rem        <= req.b;
          cnt        <= 5'd0;
          lo         <= 16'd1;
          hi         <= ROOT_HI;
          res_value  <= 32'd0;
          res_status <= ST_OK;
          // Resolve guarded and trivial cases up front
          unique case (req.cmd) inside
            OP_ADD, OP_SUB, OP_MUL, OP_POW, OP_SQUARE, OP_CUBE: ;
            OP_DIV: begin
              if (req.b == 32'd0) begin
                res_value  <= DIV_ZERO_VALUE;
                res_status <= ST_DIV_ZERO;
              end
            end
            OP_MOD: begin
              if (req.b == 32'd0) begin
                res_status <= ST_MOD_ZERO;
              end
            end
            OP_ROOT: begin
              if (req.a[31] || req.a == 32'd0) begin
                res_status <= ST_ROOT_NEG;
              end
            end
            OP_PASS: res_value <= req.a;
            default: res_status <= ST_BAD_OP;
          endcase
        end
      end
      S_ADD: res_value <= add_sum[31:0];
      S_MUL1: begin
        acc       <= mul_p;
        res_value <= mul_p;
      end
      S_MUL2: res_value <= mul_p;
      // Multiply the accumulator in when the exponent bit is set
      S_POW_MUL: begin
        if (rem[0]) begin
          acc <= mul_p;
        end
      end
      // Square the base and advance the exponent
      S_POW_SQ: begin
        aux       <= mul_p;
        rem       <= {1'b0, rem[31:1]};
        res_value <= acc;
      end
      S_ABS_A: acc <= opa[31] ? add_sum[31:0] : opa;
      S_ABS_B: begin
        aux <= opb[31] ? add_sum[31:0] : opb;
        rem <= 32'd0;
      end
      // Restoring division, one quotient bit per cycle
      S_DIV: begin
        rem <= borrow ? add_x[31:0] : add_sum[31:0];
        acc <= {acc[30:0], ~borrow};
        cnt <= 5'(cnt + 5'd1);
      end
      S_DIV_FIX: res_value <= fix_neg ? add_sum[31:0] : fix_val;
      // Binary search for the root
      S_ROOT_MID: begin
        mid       <= add_sum[16:1];
        res_value <= {16'b0, lo};
      end
      S_ROOT_MUL: rem <= mul_p;
      S_ROOT_CMP: begin
        if (borrow) begin
          lo <= mid_inc[15:0];
        end else begin
          hi <= mid;
        end
      end
      default: ;
    endcase
  end

  assign rsp.value  = res_value;
  assign rsp.status = res_status;

  // A division runs all 32 steps
  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt != 5'd31) |=> (state == S_DIV))
    else $error("division left early");

  // Search window never inverts
  a_root_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT_MID || state == S_ROOT_MUL || state == S_ROOT_CMP) |-> (lo <= hi))
    else $error("root search window inverted");

  // Zero divisor carries its fixed value
  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res_status == ST_DIV_ZERO) |-> (res_value == DIV_ZERO_VALUE))
    else $error("zero divisor value wrong");

  // New work only starts from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> idle)
    else $error("start while busy");

  // A finished result holds until taken
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (done && !take) |=> (done && $stable(res_value) && $stable(res_status)))
    else $error("result changed before take");

endmodule

// ===== rtl/integer_calculator_alu_top.sv =====
// Top level of the integer calculator ALU: stream ports, output register and engine.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata: cmd, operand_a, operand_b
//   m_*     | out | m_tvalid/m_tready  | m_tdata: result_value, status
//
// Requests share the one 32x32 multiplier and one 34-bit adder: add/sub use the adder,
// mul/square a multiply and cube a second one; pass, invalid opcodes and rejected
//   arguments go straight to the result, divide/modulo run a restoring loop, power
//   multiplies and squares per exponent bit, and root runs a binary search.
// rst clears the sequencer and the output valid; s_tready is high only when idle,
// so the next request is taken no earlier than the cycle after a result is handed over.
// A result waiting in the output register lets the next request run; the engine
// then holds its own result until the output register frees up.
module integer_calculator_alu_top
  import ica_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [3:0] cmd, [35:4] operand_a, [67:36] operand_b
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] result_value, [34:32] status
);

  req_t req;
  rsp_t rsp;
  logic start, take, idle, done;

  // Unpack the request
  assign req.cmd = s_tdata[3:0];
  assign req.a   = s_tdata[35:4];
  assign req.b   = s_tdata[67:36];

  assign s_tready = idle;
  assign start    = s_tvalid & s_tready;
  assign take     = done & (~m_tvalid | m_tready);

  ica_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .take  (take),
    .idle  (idle),
    .done  (done),
    .rsp   (rsp)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {5'b0, rsp.status, rsp.value};
    end
  end

endmodule
